>>> rtl/pnfe_pkg.sv
package pnfe_pkg;

    // Default sizes of the net
    localparam int PLACES_DEF      = 32;
    localparam int TRANSITIONS_DEF = 32;
    localparam int ARCS_DEF        = 5;

    // Fixed field widths of the request and result
    localparam int TOKEN_BITS = 16;
    localparam int OP_W       = 3;
    localparam int TRANS_W    = 5;
    localparam int PLACE_W    = 5;
    localparam int WEIGHT_W   = 8;
    localparam int INDEX_W    = 6;

    // Request tdata layout, lowest bit first
    localparam int S_TRANS_LSB  = 0;
    localparam int S_PLACE_LSB  = S_TRANS_LSB + TRANS_W;
    localparam int S_WEIGHT_LSB = S_PLACE_LSB + PLACE_W;
    localparam int S_INIT_LSB   = S_WEIGHT_LSB + WEIGHT_W;
    localparam int S_FIELD_W    = S_INIT_LSB + TOKEN_BITS;
    localparam int S_TDATA_W    = ((S_FIELD_W + 7) / 8) * 8;

    // Result tdata layout, lowest bit first
    localparam int M_FIELD_W = INDEX_W + 1 + TOKEN_BITS;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_PLACE   = 3'd0,
        OP_ADD_TRANS   = 3'd1,
        OP_ADD_IN_ARC  = 3'd2,
        OP_ADD_OUT_ARC = 3'd3,
        OP_FIRE        = 3'd4,
        OP_READ        = 3'd5,
        OP_TEST        = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FILL_USE,
        ST_ARC_RD,
        ST_TOK_RD,
        ST_TOK_USE,
        ST_RD_WAIT,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        PH_CHECK,
        PH_SUB,
        PH_ADD
    } t_phase;

    // Clamp a one-bit-wider sum to the signed token range
    function automatic logic [TOKEN_BITS-1:0] sat_tok(input logic [TOKEN_BITS:0] v);
        logic [TOKEN_BITS-1:0] lim;
        lim = {1'b0, {(TOKEN_BITS-1){1'b1}}};
        if (v[TOKEN_BITS] != v[TOKEN_BITS-1]) begin
            return v[TOKEN_BITS] ? ~lim : lim;
        end
        return v[TOKEN_BITS-1:0];
    endfunction

endpackage

>>> rtl/pnfe_ram.sv
module pnfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/petri_net_firing_engine.sv
// Test checks every input arc against its place's tokens; fire then subtracts on the
// input arcs and adds on the output arcs. One request at a time; each arc costs an
// arc-memory read, a token read and a compare or write-back on the single token memory.
// Reset (i_rst_n low, synchronous): counters, fill and token valid bits cleared, so
// every place reads zero tokens and every arc slot is empty at once; no clearing pass.
module petri_net_firing_engine
    import pnfe_pkg::*;
#(
    parameter int PLACES      = PLACES_DEF,
    parameter int TRANSITIONS = TRANSITIONS_DEF,
    parameter int ARCS        = ARCS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: transition[4:0], place[9:5], arc_weight[17:10], initial_count[33:18], zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: op[2:0]
    input  logic [OP_W-1:0]      i_s_tuser,
    // result channel
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: new_index[5:0], success[6], token_count[22:7], zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int PW        = $clog2(PLACES);
    localparam int TW        = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
    localparam int FW        = $clog2(ARCS + 1);
    localparam int UW        = $clog2(PLACES + 1);
    localparam int XW        = $clog2(TRANSITIONS + 1);
    localparam int ARC_DEPTH = 2 * TRANSITIONS * ARCS;
    localparam int AAW       = $clog2(ARC_DEPTH);
    localparam int ARC_W     = PLACE_W + WEIGHT_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    t_op                   r_op, n_op;
    logic [TRANS_W-1:0]    r_trans, n_trans;
    logic [PLACE_W-1:0]    r_place, n_place;
    logic [WEIGHT_W-1:0]   r_weight, n_weight;
    logic [TOKEN_BITS-1:0] r_init, n_init;
    logic [UW-1:0]         r_pl_used, n_pl_used;
    logic [XW-1:0]         r_tr_used, n_tr_used;
    logic [FW-1:0]         r_in_fill, n_in_fill;
    logic [FW-1:0]         r_out_fill, n_out_fill;
    logic [FW-1:0]         r_slot, n_slot;
    logic [PLACE_W-1:0]    r_arc_p, n_arc_p;
    logic [WEIGHT_W-1:0]   r_arc_w, n_arc_w;
    logic [INDEX_W-1:0]    r_idx, n_idx;
    logic                  r_ok, n_ok;
    logic [TOKEN_BITS-1:0] r_tok, n_tok;
    logic                  r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data, n_m_data;
    logic [PLACES-1:0]      r_tok_vld;
    logic [TRANSITIONS-1:0] r_fill_vld;
    logic                   r_tok_rvld;
    logic                   r_fill_rvld;

    // ---------------------------------------------------------------
    // Memory ports
    // ---------------------------------------------------------------
    logic                  tok_we;
    logic [PW-1:0]         tok_waddr;
    logic [TOKEN_BITS-1:0] tok_wdata;
    logic [PW-1:0]         tok_raddr;
    logic [TOKEN_BITS-1:0] tok_rdata;

    logic                  fill_we;
    logic [TW-1:0]         fill_addr;
    logic [2*FW-1:0]       fill_wdata;
    logic [2*FW-1:0]       fill_rdata;

    logic                  arc_we;
    logic [AAW-1:0]        arc_addr;
    logic [ARC_W-1:0]      arc_wdata;
    logic [ARC_W-1:0]      arc_rdata;

    // ---------------------------------------------------------------
    // Helper terms
    // ---------------------------------------------------------------
    logic                  s_accept;
    logic                  t_ok;
    logic                  p_ok;
    logic                  out_free;
    logic [TOKEN_BITS-1:0] tok_cur;
    logic [FW-1:0]         fill_in_cur;
    logic [FW-1:0]         fill_out_cur;
    logic [FW-1:0]         fill_sel;
    logic                  arc_dir;
    logic [FW-1:0]         arc_slot;
    logic [FW-1:0]         pass_limit;
    logic                  pass_end;
    logic [TOKEN_BITS:0]   tok_ext;
    logic [TOKEN_BITS:0]   w_ext;
    logic [TOKEN_BITS:0]   sub_diff;
    logic [TOKEN_BITS:0]   add_sum;
    logic                  tok_short;
    logic [PLACE_W-1:0]    arc_rd_place;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign out_free   = !r_m_valid || i_m_tready;

    assign t_ok = (32'(r_trans) < TRANSITIONS);
    assign p_ok = (32'(r_place) < PLACES);

    // Slots and places never written since reset read as empty / zero
    assign tok_cur      = r_tok_rvld ? tok_rdata : '0;
    assign fill_in_cur  = r_fill_rvld ? fill_rdata[FW-1:0] : '0;
    assign fill_out_cur = r_fill_rvld ? fill_rdata[2*FW-1:FW] : '0;
    assign fill_sel     = (r_op == OP_ADD_OUT_ARC) ? fill_out_cur : fill_in_cur;

    // Arc slot address: input arcs in the lower half, output arcs in the upper
    assign arc_dir  = (r_state == ST_FILL_USE) ? (r_op == OP_ADD_OUT_ARC)
                                                : (r_phase == PH_ADD);
    assign arc_slot = (r_state == ST_FILL_USE) ? fill_sel : r_slot;
    assign arc_addr = AAW'(r_trans) * AAW'(ARCS) + AAW'(arc_slot)
                    + (arc_dir ? AAW'(TRANSITIONS * ARCS) : AAW'(0));
    assign arc_wdata    = {r_weight, r_place};
    assign arc_rd_place = arc_rdata[PLACE_W-1:0];

    assign fill_addr  = TW'(r_trans);
    assign fill_wdata = (r_op == OP_ADD_OUT_ARC) ? {FW'(fill_out_cur + 1'b1), fill_in_cur}
                                                 : {fill_out_cur, FW'(fill_in_cur + 1'b1)};

    assign tok_raddr = (r_state == ST_TOK_RD) ? PW'(arc_rd_place) : PW'(r_place);

    assign pass_limit = (r_phase == PH_ADD) ? r_out_fill : r_in_fill;
    assign pass_end   = (r_slot == pass_limit);

    // Token arithmetic one bit wider, then clamp
    assign tok_ext   = {tok_cur[TOKEN_BITS-1], tok_cur};
    assign w_ext     = (TOKEN_BITS + 1)'(r_arc_w);
    assign sub_diff  = tok_ext - w_ext;
    assign add_sum   = tok_ext + w_ext;
    assign tok_short = sub_diff[TOKEN_BITS];

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    pnfe_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (PLACES)
    ) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (tok_we),
        .i_waddr (tok_waddr),
        .i_wdata (tok_wdata),
        .i_raddr (tok_raddr),
        .o_rdata (tok_rdata)
    );

    // Per-transition fill counts: {output fill, input fill}
    pnfe_ram #(
        .WIDTH (2 * FW),
        .DEPTH (TRANSITIONS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_addr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_addr),
        .o_rdata (fill_rdata)
    );

    // Arc slots: {weight, place}
    pnfe_ram #(
        .WIDTH (ARC_W),
        .DEPTH (ARC_DEPTH)
    ) u_arc_ram (
        .i_clk   (i_clk),
        .i_we    (arc_we),
        .i_waddr (arc_addr),
        .i_wdata (arc_wdata),
        .i_raddr (arc_addr),
        .o_rdata (arc_rdata)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (r_op) inside
                    OP_ADD_IN_ARC, OP_ADD_OUT_ARC: begin
                        n_state = (t_ok && p_ok) ? ST_FILL_USE : ST_RESULT;
                    end
                    OP_FIRE, OP_TEST: begin
                        n_state = t_ok ? ST_FILL_USE : ST_RESULT;
                    end
                    OP_READ: begin
                        n_state = p_ok ? ST_RD_WAIT : ST_RESULT;
                    end
                    default: begin
                        n_state = ST_RESULT;
                    end
                endcase
            end
            ST_FILL_USE: begin
                if (r_op == OP_FIRE || r_op == OP_TEST) begin
                    n_state = ST_ARC_RD;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_ARC_RD: begin
                if (!pass_end) begin
                    n_state = ST_TOK_RD;
                end else if (r_phase == PH_ADD || (r_phase == PH_CHECK && r_op == OP_TEST)) begin
                    n_state = ST_RESULT;
                end
            end
            ST_TOK_RD: begin
                n_state = ST_TOK_USE;
            end
            ST_TOK_USE: begin
                n_state = (r_phase == PH_CHECK && tok_short) ? ST_RESULT : ST_ARC_RD;
            end
            ST_RD_WAIT: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and memory control
    // ---------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_op       = r_op;
        n_trans    = r_trans;
        n_place    = r_place;
        n_weight   = r_weight;
        n_init     = r_init;
        n_pl_used  = r_pl_used;
        n_tr_used  = r_tr_used;
        n_in_fill  = r_in_fill;
        n_out_fill = r_out_fill;
        n_slot     = r_slot;
        n_arc_p    = r_arc_p;
        n_arc_w    = r_arc_w;
        n_idx      = r_idx;
        n_ok       = r_ok;
        n_tok      = r_tok;
        n_m_data   = r_m_data;
        n_m_valid  = r_m_valid && !i_m_tready;
        tok_we     = 1'b0;
        tok_waddr  = PW'(r_arc_p);
        tok_wdata  = sat_tok(sub_diff);
        fill_we    = 1'b0;
        arc_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // latch the request
                if (s_accept) begin
                    n_op     = t_op'(i_s_tuser);
                    n_trans  = i_s_tdata[S_TRANS_LSB +: TRANS_W];
                    n_place  = i_s_tdata[S_PLACE_LSB +: PLACE_W];
                    n_weight = i_s_tdata[S_WEIGHT_LSB +: WEIGHT_W];
                    n_init   = i_s_tdata[S_INIT_LSB +: TOKEN_BITS];
                end
            end
            ST_DISPATCH: begin
                n_idx   = '0;
                n_ok    = 1'b0;
                n_tok   = '0;
                n_phase = PH_CHECK;
                n_slot  = '0;
                unique case (r_op) inside
                    OP_ADD_PLACE: begin
                        if (32'(r_pl_used) < PLACES) begin
                            tok_we    = 1'b1;
                            tok_waddr = PW'(r_pl_used);
                            tok_wdata = r_init;
                            n_idx     = INDEX_W'(r_pl_used);
                            n_ok      = 1'b1;
                            n_pl_used = UW'(r_pl_used + 1'b1);
                        end else begin
                            n_idx = '1;
                        end
                    end
                    OP_ADD_TRANS: begin
                        if (32'(r_tr_used) < TRANSITIONS) begin
                            n_idx     = INDEX_W'(r_tr_used);
                            n_ok      = 1'b1;
                            n_tr_used = XW'(r_tr_used + 1'b1);
                        end else begin
                            n_idx = '1;
                        end
                    end
                    default: begin
                        // fill count and token reads are issued by address alone
                    end
                endcase
            end
            ST_FILL_USE: begin
                n_in_fill  = fill_in_cur;
                n_out_fill = fill_out_cur;
                if (r_op == OP_ADD_IN_ARC || r_op == OP_ADD_OUT_ARC) begin
                    // store into the first free slot, drop when none is left
                    if (32'(fill_sel) < ARCS) begin
                        arc_we  = 1'b1;
                        fill_we = 1'b1;
                        n_ok    = 1'b1;
                    end
                end
            end
            ST_ARC_RD: begin
                if (pass_end) begin
                    n_slot = '0;
                    unique case (r_phase)
                        PH_CHECK: begin
                            if (r_op == OP_TEST) begin
                                n_ok = 1'b1;
                            end else begin
                                n_phase = PH_SUB;
                            end
                        end
                        PH_SUB: begin
                            n_phase = PH_ADD;
                        end
                        PH_ADD: begin
                            // fire done: drop back to the check phase
                            n_ok    = 1'b1;
                            n_phase = PH_CHECK;
                        end
                        default: begin
                            n_phase = PH_CHECK;
                        end
                    endcase
                end
            end
            ST_TOK_RD: begin
                n_arc_p = arc_rd_place;
                n_arc_w = arc_rdata[PLACE_W +: WEIGHT_W];
            end
            ST_TOK_USE: begin
                unique case (r_phase)
                    PH_CHECK: begin
                        if (!tok_short) begin
                            n_slot = FW'(r_slot + 1'b1);
                        end
                    end
                    PH_SUB: begin
                        tok_we = 1'b1;
                        n_slot = FW'(r_slot + 1'b1);
                    end
                    PH_ADD: begin
                        tok_we    = 1'b1;
                        tok_wdata = sat_tok(add_sum);
                        n_slot    = FW'(r_slot + 1'b1);
                    end
                    default: begin
                        n_slot = r_slot;
                    end
                endcase
            end
            ST_RD_WAIT: begin
                n_tok = tok_cur;
                n_ok  = 1'b1;
            end
            ST_RESULT: begin
                // hand the result over once the output register is free
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = M_TDATA_W'({r_tok, r_ok, r_idx});
                end
            end
            default: begin
                n_ok = r_ok;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_CHECK;
            r_pl_used  <= '0;
            r_tr_used  <= '0;
            r_m_valid  <= 1'b0;
            r_tok_vld  <= '0;
            r_fill_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pl_used <= n_pl_used;
            r_tr_used <= n_tr_used;
            r_m_valid <= n_m_valid;
            if (tok_we) begin
                r_tok_vld[tok_waddr] <= 1'b1;
            end
            if (fill_we) begin
                r_fill_vld[fill_addr] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_trans     <= n_trans;
        r_place     <= n_place;
        r_weight    <= n_weight;
        r_init      <= n_init;
        r_in_fill   <= n_in_fill;
        r_out_fill  <= n_out_fill;
        r_slot      <= n_slot;
        r_arc_p     <= n_arc_p;
        r_arc_w     <= n_arc_w;
        r_idx       <= n_idx;
        r_ok        <= n_ok;
        r_tok       <= n_tok;
        r_m_data    <= n_m_data;
        // valid bits are registered alongside the memory reads so they line up with the read data
        r_tok_rvld  <= r_tok_vld[tok_raddr];
        r_fill_rvld <= r_fill_vld[fill_addr];
    end

`ifndef SYNTHESIS
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ARC_RD) |-> (r_slot <= pass_limit))
        else $error("arc slot walked past the fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ARC_RD) |-> (32'(r_in_fill) <= ARCS && 32'(r_out_fill) <= ARCS))
        else $error("fill count beyond arc slots");

    a_update_only_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_CHECK) |-> (r_op == OP_FIRE))
        else $error("token update pass outside a fire request");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_RESULT))
        else $error("result raised outside the result state");

    a_places_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pl_used) <= PLACES)
        else $error("place count beyond capacity");
`endif

endmodule
